>>> src/rsad_pkg.sv
// rsad_pkg: shared types and constants for the private exponent derivation block
`default_nettype none

package rsad_pkg;

   localparam int EXP_BITS            = 17;
   localparam logic [EXP_BITS-1:0] EXP_RESET = 17'd257;
   localparam int FACTOR_BITS_DEFAULT = 16;
   localparam int FIELD_BITS          = 16;
   localparam int OUT_BITS            = 32;

   typedef struct packed {
      logic [FIELD_BITS-1:0] prime_p;
      logic [FIELD_BITS-1:0] prime_q;
   } req_type;

   typedef struct packed {
      logic [OUT_BITS-1:0] modulus;
      logic [OUT_BITS-1:0] private_exponent;
      logic                inverse_valid;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_N,
      ST_MUL_F,
      ST_CHECK,
      ST_LOOP,
      ST_ALIGN,
      ST_SUB,
      ST_UPDATE,
      ST_FINAL,
      ST_NEGATE,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

>>> src/rsad_addsub.sv
// rsad_addsub: shared compare/subtract and add unit used by the euclid divider and the fix-up
`default_nettype none

module rsad_addsub #(
   parameter int W = 32
) (
   input  wire logic [W-1:0] a,
   input  wire logic [W-1:0] b,
   input  wire logic [W-1:0] c,
   input  wire logic [W-1:0] d,
   output logic             ge,
   output logic [W-1:0]     diff,
   output logic [W-1:0]     sum
);

   logic [W:0] diff_full;

   always_comb begin
      diff_full = {1'b0, a} - {1'b0, b};
      // borrow clear means a >= b
      ge        = ~diff_full[W];
      diff      = diff_full[W-1:0];
      sum       = c + d;
   end

endmodule

`default_nettype wire

>>> src/rsa_private_exponent_derive.sv
// rsa_private_exponent_derive: modulus, totient and modular inverse of the public exponent
//
// usage: drive req_data with the two factors and pulse start while busy is low; the beat is
// taken at that edge and busy rises on the next cycle. the block then works alone until the
// result beat appears on rsp_data with rsp_strobe high for exactly one cycle, after which busy
// falls. the receiver cannot hold the beat off, so it must capture it in that cycle.
// the public exponent lives in a single register written through csr_we / csr_wdata; the user
// must write it only while busy is low; the block does not enforce this; reset loads 257.
// sequence: the multiplier forms the modulus, then the totient, and a check follows; each
// euclid step then runs the shift-and-subtract divider, which aligns the divisor one bit a
// cycle, then subtracts one bit a cycle while accumulating the coefficient. finally a fix-up
// reduces the coefficient and, if an inverse exists, negates it for an odd step count, and
// the output beat follows. the run time is set by the number of euclid steps and the
// quotient widths, all going through the single add/sub unit; a zero totient goes from the
// check straight to the result beat.
// one beat is in flight at a time; the next start is taken once busy is low again.
// reset: synchronous, active high; it returns the sequencer to idle, drops any beat in work
// and restores the exponent register.
`default_nettype none

module rsa_private_exponent_derive #(
   parameter int FACTOR_BITS = rsad_pkg::FACTOR_BITS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire rsad_pkg::req_type             req_data,
   output logic                               rsp_strobe,
   output rsad_pkg::rsp_type                  rsp_data,
   input  wire logic                          csr_we,
   input  wire logic [rsad_pkg::EXP_BITS-1:0] csr_wdata
);

   import rsad_pkg::*;

   localparam int FB = FACTOR_BITS;
   localparam int TW = 2 * FB;
   localparam int W  = (TW > EXP_BITS) ? TW : EXP_BITS;
   localparam int KW = $clog2(W);

   state_type state_ff, state_in;

   logic [EXP_BITS-1:0] exp_ff, exp_in;
   logic [FB-1:0]       p_ff, p_in, q_ff, q_in;
   logic [TW-1:0]       f_ff, f_in;
   logic [W-1:0]        old_r_ff, old_r_in, r_ff, r_in;
   logic [W-1:0]        old_m_ff, old_m_in, m_ff, m_in;
   logic [W-1:0]        rem_ff, rem_in, nm_ff, nm_in;
   logic [W-1:0]        ds_ff, ds_in, ms_ff, ms_in;
   logic [KW-1:0]       k_ff, k_in;
   logic                idx_ff, idx_in;
   logic [OUT_BITS-1:0] modulus_ff, modulus_in, d_ff, d_in;
   logic                valid_ff, valid_in;

   logic [FB-1:0] mul_a, mul_b, pm, qm;
   logic [TW-1:0] prod;
   logic [W-1:0]  u_a, u_b, u_c, u_d, u_diff, u_sum;
   logic          u_ge;

   rsad_addsub #(
      .W (W)
   ) u_addsub (
      .a    (u_a),
      .b    (u_b),
      .c    (u_c),
      .d    (u_d),
      .ge   (u_ge),
      .diff (u_diff),
      .sum  (u_sum)
   );

   // factors below two saturate to zero after the decrement
   always_comb begin
      pm = (p_ff == '0) ? '0 : p_ff - FB'(1);
      qm = (q_ff == '0) ? '0 : q_ff - FB'(1);
      if (state_ff == ST_MUL_N) begin
         mul_a = p_ff;
         mul_b = q_ff;
      end else begin
         mul_a = pm;
         mul_b = qm;
      end
      prod = TW'(mul_a) * TW'(mul_b);
   end

   // operand selection for the shared unit
   always_comb begin
      u_a = rem_ff;
      u_b = ds_ff;
      u_c = nm_ff;
      u_d = ms_ff;
      unique case (state_ff)
         ST_ALIGN:  u_a = rem_ff >> 1;
         ST_FINAL: begin
            u_a = old_m_ff;
            u_b = W'(f_ff);
         end
         ST_NEGATE: begin
            u_a = W'(f_ff);
            u_b = nm_ff;
         end
         default: begin
            u_a = rem_ff;
            u_b = ds_ff;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (start) state_in = ST_MUL_N;
         ST_MUL_N:  state_in = ST_MUL_F;
         ST_MUL_F:  state_in = ST_CHECK;
         ST_CHECK:  state_in = (f_ff == '0) ? ST_DONE : ST_LOOP;
         ST_LOOP:   state_in = (r_ff == '0) ? ST_FINAL : ST_ALIGN;
         ST_ALIGN:  if (!u_ge) state_in = ST_SUB;
         ST_SUB:    if (k_ff == '0) state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_LOOP;
         ST_FINAL:  state_in = (old_r_ff != W'(1)) ? ST_DONE : ST_NEGATE;
         ST_NEGATE: state_in = ST_DONE;
         ST_DONE:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath updates
   always_comb begin
      exp_in     = csr_we ? csr_wdata : exp_ff;
      p_in       = p_ff;
      q_in       = q_ff;
      f_in       = f_ff;
      old_r_in   = old_r_ff;
      r_in       = r_ff;
      old_m_in   = old_m_ff;
      m_in       = m_ff;
      rem_in     = rem_ff;
      nm_in      = nm_ff;
      ds_in      = ds_ff;
      ms_in      = ms_ff;
      k_in       = k_ff;
      idx_in     = idx_ff;
      modulus_in = modulus_ff;
      d_in       = d_ff;
      valid_in   = valid_ff;
      unique case (state_ff)
         ST_IDLE: begin
            p_in     = FB'(req_data.prime_p);
            q_in     = FB'(req_data.prime_q);
            old_r_in = W'(exp_ff);
            old_m_in = W'(1);
            m_in     = '0;
            idx_in   = 1'b0;
         end
         ST_MUL_N: modulus_in = OUT_BITS'(prod);
         ST_MUL_F: begin
            f_in = prod;
            r_in = W'(prod);
         end
         ST_CHECK: begin
            d_in     = '0;
            valid_in = 1'b0;
         end
         ST_LOOP: begin
            rem_in = old_r_ff;
            nm_in  = old_m_ff;
            ds_in  = r_ff;
            ms_in  = m_ff;
            k_in   = '0;
         end
         ST_ALIGN: begin
            // widen the divisor while it still fits twice into the remainder
            if (u_ge) begin
               ds_in = ds_ff << 1;
               ms_in = ms_ff << 1;
               k_in  = k_ff + KW'(1);
            end
         end
         ST_SUB: begin
            if (u_ge) begin
               rem_in = u_diff;
               nm_in  = u_sum;
            end
            if (k_ff != '0) begin
               ds_in = ds_ff >> 1;
               ms_in = ms_ff >> 1;
               k_in  = k_ff - KW'(1);
            end
         end
         ST_UPDATE: begin
            old_r_in = r_ff;
            r_in     = rem_ff;
            old_m_in = m_ff;
            m_in     = nm_ff;
            idx_in   = ~idx_ff;
         end
         ST_FINAL: begin
            // coefficient magnitude never exceeds the totient, one subtract reduces it
            nm_in    = u_ge ? u_diff : old_m_ff;
            d_in     = '0;
            valid_in = 1'b0;
         end
         ST_NEGATE: begin
            // odd step count means the coefficient is negative
            if (idx_ff && (nm_ff != '0)) d_in = OUT_BITS'(u_diff);
            else                         d_in = OUT_BITS'(nm_ff);
            valid_in = 1'b1;
         end
         default: begin
            d_in = d_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         exp_ff   <= EXP_RESET;
      end else begin
         state_ff <= state_in;
         exp_ff   <= exp_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff       <= p_in;
      q_ff       <= q_in;
      f_ff       <= f_in;
      old_r_ff   <= old_r_in;
      r_ff       <= r_in;
      old_m_ff   <= old_m_in;
      m_ff       <= m_in;
      rem_ff     <= rem_in;
      nm_ff      <= nm_in;
      ds_ff      <= ds_in;
      ms_ff      <= ms_in;
      k_ff       <= k_in;
      idx_ff     <= idx_in;
      modulus_ff <= modulus_in;
      d_ff       <= d_in;
      valid_ff   <= valid_in;
   end

   always_comb begin
      busy                      = (state_ff != ST_IDLE);
      rsp_strobe                = (state_ff == ST_DONE);
      rsp_data.modulus          = modulus_ff;
      rsp_data.private_exponent = d_ff;
      rsp_data.inverse_valid    = valid_ff;
   end

endmodule

`default_nettype wire
